// ===== rtl/core/d2f_pkg.sv =====
// Shared constants and types for the decimal to single-float converter.
`default_nettype none

package d2f_pkg;

  // Defaults for the top-level parameters.
  localparam int IntegerBitsDef   = 15;
  localparam int FractionScaleDef = 10000;

  // Fixed IEEE-754 single-precision field widths.
  localparam int MantBits  = 23;
  localparam int ExpBits   = 8;
  // Exponent of 1.0 with bias 127.
  localparam int ExpOne    = 127;
  // Width of the fraction digit field at the ports.
  localparam int FracDigitBits = 14;
  // Restoring steps done in one fraction stage; the last stage may do fewer.
  localparam int StepsPerStage = 8;

  // Per-word control fields carried down the pipeline.
  typedef struct packed {
    logic               sign;
    logic               zero;
    logic               ovf;
    logic [ExpBits-1:0] expo;
  } d2f_meta_t;

endpackage

`default_nettype wire

// ===== rtl/core/decimal_to_single_float_converter.sv =====
// Top level of the decimal fixed-point to IEEE-754 single-precision converter.
//
// Converts a sign, an unsigned integer part and a fraction given as a count over
// FRACTION_SCALE into the sign, biased exponent and truncated 23-bit mantissa of a
// single-precision float; a zero input gives all zeros, and an all-ones integer part
// with a nonzero fraction raises out_of_range_o with the other fields zero. The
// datapath is a pipeline that takes one word per cycle while the output does not
// stall: an input register, the fraction stages and an output register. The
// fraction stages form a restoring divider: one quotient bit per doubling step,
// up to eight steps per stage. Stall on the output side backs up stage by stage,
// and in_stall_o rises only when every stage holds a word.
`default_nettype none

module decimal_to_single_float_converter #(
  parameter int INTEGER_BITS   = d2f_pkg::IntegerBitsDef,
  parameter int FRACTION_SCALE = d2f_pkg::FractionScaleDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                negative_i,
  input  wire logic [INTEGER_BITS-1:0]             integer_part_i,
  input  wire logic [d2f_pkg::FracDigitBits-1:0]   fraction_digits_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     sign_bit_o,
  output logic [d2f_pkg::ExpBits-1:0]              biased_exponent_o,
  output logic [d2f_pkg::MantBits-1:0]             mantissa_o,
  output logic                                     out_of_range_o
);

  localparam int RW   = $clog2(FRACTION_SCALE);
  localparam int KMAX = RW;
  localparam int W    = d2f_pkg::MantBits + KMAX;
  localparam int SPS  = d2f_pkg::StepsPerStage;
  localparam int NDS  = (W + SPS - 1) / SPS;
  localparam int SW   = $clog2(INTEGER_BITS + W);
  localparam int NW   = $clog2(INTEGER_BITS);
  localparam int KW   = $clog2(KMAX + 1);

  logic                    vld   [NDS+1];
  logic                    rdy   [NDS+1];
  d2f_pkg::d2f_meta_t      meta  [NDS+1];
  logic [INTEGER_BITS-1:0] ip    [NDS+1];
  logic [RW-1:0]           rem   [NDS+1];
  logic [W-1:0]            bits  [NDS+1];
  logic [SW-1:0]           shift [NDS+1];
  logic                    rdy_pack;

  assign bits[0]    = '0;
  assign rdy_pack   = !out_valid_o || !out_stall_i;
  assign in_stall_o = !rdy[0];

  // A stage takes a new word when it is empty or its word moves on.
  always_comb begin
    for (int g = 0; g < NDS; g++) begin
      rdy[g] = !vld[g] || rdy[g+1];
    end
    rdy[NDS] = !vld[NDS] || rdy_pack;
  end

  d2f_prep #(
    .IB   (INTEGER_BITS),
    .SCALE(FRACTION_SCALE),
    .RW   (RW),
    .KMAX (KMAX),
    .W    (W),
    .SW   (SW),
    .NW   (NW),
    .KW   (KW)
  ) u_prep (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (in_valid_i),
    .load_i           (rdy[0]),
    .negative_i       (negative_i),
    .integer_part_i   (integer_part_i),
    .fraction_digits_i(fraction_digits_i),
    .valid_o          (vld[0]),
    .meta_o           (meta[0]),
    .ip_o             (ip[0]),
    .rem_o            (rem[0]),
    .shift_o          (shift[0])
  );

  for (genvar g = 0; g < NDS; g++) begin : g_frac
    localparam int NStep = (g == NDS - 1) ? (W - (NDS - 1) * SPS) : SPS;

    d2f_frac_stage #(
      .IB   (INTEGER_BITS),
      .SCALE(FRACTION_SCALE),
      .RW   (RW),
      .W    (W),
      .SW   (SW),
      .NSTEP(NStep)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(vld[g]),
      .load_i (rdy[g+1]),
      .meta_i (meta[g]),
      .ip_i   (ip[g]),
      .rem_i  (rem[g]),
      .bits_i (bits[g]),
      .shift_i(shift[g]),
      .valid_o(vld[g+1]),
      .meta_o (meta[g+1]),
      .ip_o   (ip[g+1]),
      .rem_o  (rem[g+1]),
      .bits_o (bits[g+1]),
      .shift_o(shift[g+1])
    );
  end

  d2f_pack #(
    .IB(INTEGER_BITS),
    .W (W),
    .SW(SW)
  ) u_pack (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (vld[NDS]),
    .load_i           (rdy_pack),
    .meta_i           (meta[NDS]),
    .ip_i             (ip[NDS]),
    .bits_i           (bits[NDS]),
    .shift_i          (shift[NDS]),
    .valid_o          (out_valid_o),
    .sign_bit_o       (sign_bit_o),
    .biased_exponent_o(biased_exponent_o),
    .mantissa_o       (mantissa_o),
    .out_of_range_o   (out_of_range_o)
  );

  // Range errors carry no number.
  a_ovf_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |->
      !sign_bit_o && (biased_exponent_o == '0) && (mantissa_o == '0))
    else $error("out_of_range word carries nonzero fields");

  // A zero exponent only comes from a zero or a range error.
  a_zero_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (biased_exponent_o == '0) |-> !sign_bit_o && (mantissa_o == '0))
    else $error("zero exponent with nonzero sign or mantissa");

  // Input stalls only when the whole pipeline is backed up.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && vld[0] && vld[NDS])
    else $error("input stalled while pipeline has room");

endmodule

`default_nettype wire

// ===== rtl/core/d2f_prep.sv =====
// Input stage: saturate the fraction, classify the word, find exponent and alignment shift.
`default_nettype none

module d2f_prep #(
  parameter int IB    = d2f_pkg::IntegerBitsDef,
  parameter int SCALE = d2f_pkg::FractionScaleDef,
  parameter int RW    = 14,
  parameter int KMAX  = 14,
  parameter int W     = 37,
  parameter int SW    = 6,
  parameter int NW    = 4,
  parameter int KW    = 4
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 valid_i,
  input  wire logic                                 load_i,
  input  wire logic                                 negative_i,
  input  wire logic [IB-1:0]                        integer_part_i,
  input  wire logic [d2f_pkg::FracDigitBits-1:0]    fraction_digits_i,
  output logic                                      valid_o,
  output d2f_pkg::d2f_meta_t                        meta_o,
  output logic [IB-1:0]                             ip_o,
  output logic [RW-1:0]                             rem_o,
  output logic [SW-1:0]                             shift_o
);

  logic [31:0]        fd32;
  logic [31:0]        fds32;
  logic               int_nz;
  logic [NW-1:0]      lead;
  logic [KW-1:0]      kpos;
  d2f_pkg::d2f_meta_t meta_d;
  logic [SW-1:0]      shift_d;
  logic               valid_q;
  d2f_pkg::d2f_meta_t meta_q;
  logic [IB-1:0]      ip_q;
  logic [RW-1:0]      rem_q;
  logic [SW-1:0]      shift_q;

  assign fd32   = 32'(fraction_digits_i);
  assign fds32  = (fd32 >= 32'(SCALE)) ? 32'(SCALE - 1) : fd32;
  assign int_nz = |integer_part_i;

  // Leading one of the integer part.
  always_comb begin
    lead = '0;
    for (int i = 0; i < IB; i++) begin
      if (integer_part_i[i]) begin
        lead = NW'(i);
      end
    end
  end

  // Position of the first one bit of the fraction: count doublings that stay below scale.
  always_comb begin
    kpos = KW'(1);
    for (int j = 1; j < KMAX; j++) begin
      if ((64'(fds32) << j) < 64'(SCALE)) begin
        kpos = kpos + KW'(1);
      end
    end
  end

  always_comb begin
    meta_d.sign = negative_i;
    meta_d.zero = !int_nz && (fds32 == 32'd0);
    meta_d.ovf  = (&integer_part_i) && (fds32 != 32'd0);
    if (int_nz) begin
      meta_d.expo = d2f_pkg::ExpBits'(32'(d2f_pkg::ExpOne) + 32'(lead));
      shift_d     = SW'(32'(W - d2f_pkg::MantBits) + 32'(lead));
    end else begin
      meta_d.expo = d2f_pkg::ExpBits'(32'(d2f_pkg::ExpOne) - 32'(kpos));
      shift_d     = SW'(32'(KMAX) - 32'(kpos));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && valid_i) begin
      meta_q  <= meta_d;
      ip_q    <= integer_part_i;
      rem_q   <= fds32[RW-1:0];
      shift_q <= shift_d;
    end
  end

  assign valid_o = valid_q;
  assign meta_o  = meta_q;
  assign ip_o    = ip_q;
  assign rem_o   = rem_q;
  assign shift_o = shift_q;

endmodule

`default_nettype wire

// ===== rtl/core/d2f_frac_stage.sv =====
// One fraction stage: a few restoring doubling steps against the decimal scale.
`default_nettype none

module d2f_frac_stage #(
  parameter int IB    = d2f_pkg::IntegerBitsDef,
  parameter int SCALE = d2f_pkg::FractionScaleDef,
  parameter int RW    = 14,
  parameter int W     = 37,
  parameter int SW    = 6,
  parameter int NSTEP = d2f_pkg::StepsPerStage
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire logic               load_i,
  input  wire d2f_pkg::d2f_meta_t meta_i,
  input  wire logic [IB-1:0]      ip_i,
  input  wire logic [RW-1:0]      rem_i,
  input  wire logic [W-1:0]       bits_i,
  input  wire logic [SW-1:0]      shift_i,
  output logic                    valid_o,
  output d2f_pkg::d2f_meta_t      meta_o,
  output logic [IB-1:0]           ip_o,
  output logic [RW-1:0]           rem_o,
  output logic [W-1:0]            bits_o,
  output logic [SW-1:0]           shift_o
);

  localparam logic [RW:0] ScaleW = (RW + 1)'(SCALE);

  logic [RW:0]        dbl;
  logic [RW-1:0]      rem_d;
  logic [W-1:0]       bits_d;
  logic               valid_q;
  d2f_pkg::d2f_meta_t meta_q;
  logic [IB-1:0]      ip_q;
  logic [RW-1:0]      rem_q;
  logic [W-1:0]       bits_q;
  logic [SW-1:0]      shift_q;

  // Double the remainder, subtract the scale when it fits, shift in the quotient bit.
  always_comb begin
    dbl    = '0;
    rem_d  = rem_i;
    bits_d = bits_i;
    for (int s = 0; s < NSTEP; s++) begin
      dbl = {rem_d, 1'b0};
      if (dbl >= ScaleW) begin
        rem_d  = RW'(dbl - ScaleW);
        bits_d = {bits_d[W-2:0], 1'b1};
      end else begin
        rem_d  = dbl[RW-1:0];
        bits_d = {bits_d[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && valid_i) begin
      meta_q  <= meta_i;
      ip_q    <= ip_i;
      rem_q   <= rem_d;
      bits_q  <= bits_d;
      shift_q <= shift_i;
    end
  end

  assign valid_o = valid_q;
  assign meta_o  = meta_q;
  assign ip_o    = ip_q;
  assign rem_o   = rem_q;
  assign bits_o  = bits_q;
  assign shift_o = shift_q;

endmodule

`default_nettype wire

// ===== rtl/core/d2f_pack.sv =====
// Output stage: align integer and fraction bits into the mantissa and register the result.
`default_nettype none

module d2f_pack #(
  parameter int IB = d2f_pkg::IntegerBitsDef,
  parameter int W  = 37,
  parameter int SW = 6
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             valid_i,
  input  wire logic                             load_i,
  input  wire d2f_pkg::d2f_meta_t               meta_i,
  input  wire logic [IB-1:0]                    ip_i,
  input  wire logic [W-1:0]                     bits_i,
  input  wire logic [SW-1:0]                    shift_i,
  output logic                                  valid_o,
  output logic                                  sign_bit_o,
  output logic [d2f_pkg::ExpBits-1:0]           biased_exponent_o,
  output logic [d2f_pkg::MantBits-1:0]          mantissa_o,
  output logic                                  out_of_range_o
);

  logic [IB+W-1:0]               aligned;
  logic                          kill;
  logic                          valid_q;
  logic                          sign_q;
  logic [d2f_pkg::ExpBits-1:0]   expo_q;
  logic [d2f_pkg::MantBits-1:0]  mant_q;
  logic                          ovf_q;

  // Drop the leading one: the mantissa sits right below it.
  assign aligned = {ip_i, bits_i} >> shift_i;
  assign kill    = meta_i.zero || meta_i.ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && valid_i) begin
      sign_q <= meta_i.sign && !kill;
      expo_q <= kill ? '0 : meta_i.expo;
      mant_q <= kill ? '0 : aligned[d2f_pkg::MantBits-1:0];
      ovf_q  <= meta_i.ovf;
    end
  end

  assign valid_o           = valid_q;
  assign sign_bit_o        = sign_q;
  assign biased_exponent_o = expo_q;
  assign mantissa_o        = mant_q;
  assign out_of_range_o    = ovf_q;

endmodule

`default_nettype wire
